// ===== hw/rtl/vprr_pkg.sv =====
// shared types and constants for the virtual page run reserver
package vprr_pkg;

  typedef enum logic [1:0] {
    OP_RESERVE = 2'd0,
    OP_RELEASE = 2'd1,
    OP_MAP     = 2'd2,
    OP_UNMAP   = 2'd3
  } vprr_op_t;

  typedef logic [1:0] vprr_status_t;

  localparam vprr_status_t ST_OK           = 2'd0;
  localparam vprr_status_t ST_NO_RUN       = 2'd1;
  localparam vprr_status_t ST_NOT_RESERVED = 2'd2;
  localparam vprr_status_t ST_NOT_MAPPED   = 2'd3;

  localparam logic [31:0] ENTRY_FREE     = 32'h0000_0000;
  localparam logic [31:0] ENTRY_RESERVED = 32'h0000_0002;

  // pages addressable through the 10-bit page field
  localparam int PAGE_FIELD_PAGES = 1024;

endpackage

// ===== hw/rtl/virtual_page_run_reserver_core.sv =====
// first-fit page run reserver over a one-word-per-page table
//
//  channel | ports                                         | direction
//  --------+-----------------------------------------------+----------
//  in      | in_valid in_stall in_operation in_page        | item in
//          | in_end_page in_count in_frame in_flags        |
//  out     | out_valid out_stall out_status out_run_start  | item out
//          | out_old_frame                                 |
//
// the page table sits in one memory (one write, one read port, registered read)
// reserve: scans for a free run of count pages, then marks each page of the run reserved
// release: reads each page in turn and frees it; map and unmap read one entry, then may write it
// after reset the table is cleared one entry a cycle, min(PAGE_COUNT, 1024) entries,
// and in_stall stays high until that pass is done
// a new item is taken while the previous result still waits under out_stall
module virtual_page_run_reserver_core
  import vprr_pkg::*;
#(
  parameter int PAGE_COUNT = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [1:0]   in_operation,
  input  logic [9:0]   in_page,
  input  logic [10:0]  in_end_page,
  input  logic [10:0]  in_count,
  input  logic [19:0]  in_frame,
  input  logic [11:0]  in_flags,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [1:0]   out_status,
  output logic [9:0]   out_run_start,
  output logic [19:0]  out_old_frame
);

  localparam int DEPTH = (PAGE_COUNT < PAGE_FIELD_PAGES) ? PAGE_COUNT : PAGE_FIELD_PAGES;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [10:0] LIMIT     = 11'(DEPTH);
  localparam logic [10:0] LIMIT_M1  = 11'(DEPTH - 1);

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_SCAN,
    S_RSV_WR,
    S_REL,
    S_PG_EV,
    S_RESP
  } state_t;

  // page table
  logic [31:0]   mem [DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [31:0]   rdata_r;

  state_t        state_r, state_nxt;
  vprr_op_t      op_r, op_nxt;
  logic [10:0]   p_r, p_nxt;        // next page to read
  logic [10:0]   ev_p_r, ev_p_nxt;  // page whose data is in rdata_r
  logic          pend_r, pend_nxt;
  logic [10:0]   run_r, run_nxt;    // free run length or pages released
  logic [10:0]   cnt_r, cnt_nxt;
  logic [10:0]   limit_r, limit_nxt;
  logic [10:0]   q_r, q_nxt;        // write pointer, also clear pointer
  logic [10:0]   last_r, last_nxt;
  logic [19:0]   frame_r, frame_nxt;
  logic [11:0]   flags_r, flags_nxt;
  vprr_status_t  status_r, status_nxt;
  logic [9:0]    start_r, start_nxt;
  logic [19:0]   oldf_r, oldf_nxt;
  logic          out_valid_r, out_valid_nxt;
  vprr_status_t  out_status_r, out_status_nxt;
  logic [9:0]    out_start_r, out_start_nxt;
  logic [19:0]   out_oldf_r, out_oldf_nxt;

  logic          in_take;
  logic          ev_free;
  logic          ev_rsvd;
  logic [10:0]   run_ev;
  logic [10:0]   done_ev;
  logic [10:0]   first_pg;

  assign in_stall = (state_r != S_IDLE);
  assign in_take  = in_valid && !in_stall;

  assign ev_free  = (rdata_r == ENTRY_FREE);
  assign ev_rsvd  = (rdata_r == ENTRY_RESERVED);
  assign run_ev   = pend_r ? (ev_free ? 11'(run_r + 11'd1) : 11'd0) : run_r;
  assign done_ev  = 11'(run_r + 11'd1);
  assign first_pg = 11'(ev_p_r + 11'd1 - cnt_r);

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_run_start = out_start_r;
  assign out_old_frame = out_oldf_r;

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    p_nxt          = p_r;
    ev_p_nxt       = ev_p_r;
    pend_nxt       = pend_r;
    run_nxt        = run_r;
    cnt_nxt        = cnt_r;
    limit_nxt      = limit_r;
    q_nxt          = q_r;
    last_nxt       = last_r;
    frame_nxt      = frame_r;
    flags_nxt      = flags_r;
    status_nxt     = status_r;
    start_nxt      = start_r;
    oldf_nxt       = oldf_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_start_nxt  = out_start_r;
    out_oldf_nxt   = out_oldf_r;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = ENTRY_FREE;
    mem_re         = 1'b0;
    mem_raddr      = '0;

    unique case (state_r)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = q_r[AW-1:0];
        mem_wdata = ENTRY_FREE;
        q_nxt     = 11'(q_r + 11'd1);
        if (q_r == LIMIT_M1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_take) begin
          op_nxt     = vprr_op_t'(in_operation);
          p_nxt      = {1'b0, in_page};
          ev_p_nxt   = {1'b0, in_page};
          pend_nxt   = 1'b0;
          run_nxt    = '0;
          cnt_nxt    = in_count;
          limit_nxt  = (in_end_page < LIMIT) ? in_end_page : LIMIT;
          frame_nxt  = in_frame;
          flags_nxt  = in_flags;
          status_nxt = ST_OK;
          start_nxt  = '0;
          oldf_nxt   = '0;
          case (vprr_op_t'(in_operation))
            OP_RESERVE: begin
              if (in_count == 11'd0) begin
                start_nxt = in_page;
                state_nxt = S_RESP;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            OP_RELEASE: begin
              state_nxt = (in_count == 11'd0) ? S_RESP : S_REL;
            end
            default: begin
              // map and unmap look at one entry
              if ({1'b0, in_page} < LIMIT) begin
                mem_re    = 1'b1;
                mem_raddr = AW'(in_page);
                state_nxt = S_PG_EV;
              end else begin
                status_nxt = (vprr_op_t'(in_operation) == OP_MAP) ? ST_NOT_RESERVED
                                                                   : ST_NOT_MAPPED;
                state_nxt  = S_RESP;
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        run_nxt = run_ev;
        if (pend_r && run_ev == cnt_r) begin
          // run found, ends at the page just checked
          q_nxt     = first_pg;
          last_nxt  = ev_p_r;
          start_nxt = first_pg[9:0];
          pend_nxt  = 1'b0;
          state_nxt = S_RSV_WR;
        end else if (p_r < limit_r) begin
          mem_re    = 1'b1;
          mem_raddr = p_r[AW-1:0];
          ev_p_nxt  = p_r;
          p_nxt     = 11'(p_r + 11'd1);
          pend_nxt  = 1'b1;
        end else begin
          status_nxt = ST_NO_RUN;
          pend_nxt   = 1'b0;
          state_nxt  = S_RESP;
        end
      end
      S_RSV_WR: begin
        mem_we    = 1'b1;
        mem_waddr = q_r[AW-1:0];
        mem_wdata = ENTRY_RESERVED;
        q_nxt     = 11'(q_r + 11'd1);
        if (q_r == last_r) begin
          state_nxt = S_RESP;
        end
      end
      S_REL: begin
        if (pend_r && !ev_rsvd) begin
          status_nxt = ST_NOT_RESERVED;
          pend_nxt   = 1'b0;
          state_nxt  = S_RESP;
        end else begin
          if (pend_r) begin
            mem_we    = 1'b1;
            mem_waddr = ev_p_r[AW-1:0];
            mem_wdata = ENTRY_FREE;
            run_nxt   = done_ev;
          end
          if (pend_r && done_ev == cnt_r) begin
            pend_nxt  = 1'b0;
            state_nxt = S_RESP;
          end else if (p_r < LIMIT) begin
            mem_re    = 1'b1;
            mem_raddr = p_r[AW-1:0];
            ev_p_nxt  = p_r;
            p_nxt     = 11'(p_r + 11'd1);
            pend_nxt  = 1'b1;
          end else begin
            // next page to release lies past the table
            status_nxt = ST_NOT_RESERVED;
            pend_nxt   = 1'b0;
            state_nxt  = S_RESP;
          end
        end
      end
      S_PG_EV: begin
        state_nxt = S_RESP;
        if (op_r == OP_MAP) begin
          if (ev_rsvd) begin
            mem_we    = 1'b1;
            mem_waddr = ev_p_r[AW-1:0];
            mem_wdata = {frame_r, flags_r};
          end else begin
            status_nxt = ST_NOT_RESERVED;
          end
        end else begin
          if (!ev_free && !ev_rsvd) begin
            oldf_nxt  = rdata_r[31:12];
            mem_we    = 1'b1;
            mem_waddr = ev_p_r[AW-1:0];
            mem_wdata = ENTRY_RESERVED;
          end else begin
            status_nxt = ST_NOT_MAPPED;
          end
        end
      end
      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_start_nxt  = start_r;
          out_oldf_nxt   = oldf_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      q_r         <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      op_r         <= op_nxt;
      p_r          <= p_nxt;
      ev_p_r       <= ev_p_nxt;
      pend_r       <= pend_nxt;
      run_r        <= run_nxt;
      cnt_r        <= cnt_nxt;
      limit_r      <= limit_nxt;
      q_r          <= q_nxt;
      last_r       <= last_nxt;
      frame_r      <= frame_nxt;
      flags_r      <= flags_nxt;
      status_r     <= status_nxt;
      start_r      <= start_nxt;
      oldf_r       <= oldf_nxt;
      out_valid_r  <= out_valid_nxt;
      out_status_r <= out_status_nxt;
      out_start_r  <= out_start_nxt;
      out_oldf_r   <= out_oldf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  // release frees one page while reading the next, never the same one
  a_no_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we && mem_re |-> mem_waddr != mem_raddr)
    else $error("read and write hit the same table entry");

  a_rose_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RESP))
    else $error("result raised outside the response state");

  a_wr_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RSV_WR |-> q_r <= last_r)
    else $error("reserve write pointer ran past the run");

  a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> run_r < cnt_r)
    else $error("scan kept going after the run was complete");

endmodule

// ===== tb/sv/tb_top.sv =====
// self-checking testbench for the first-fit virtual page run reserver
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import vprr_pkg::*;

  localparam int TABLE_PAGES  = 1024;
  localparam int IDLE_LIMIT   = 20000;
  localparam int RANDOM_ITEMS = 265;
  localparam int DRAIN_CYCLES = 50;

  typedef struct packed {
    vprr_op_t     op;
    logic [9:0]   page;
    logic [10:0]  end_page;
    logic [10:0]  count;
    logic [19:0]  frame;
    logic [11:0]  flags;
  } page_req_t;

  typedef struct packed {
    vprr_status_t status;
    logic [9:0]   run_start;
    logic [19:0]  old_frame;
  } page_resp_t;

  typedef struct packed {
    page_req_t  req;
    logic       typed;
    page_resp_t want;
  } dir_row_t;

  logic         clk;
  logic         rst_n;
  logic         in_valid;
  logic         in_stall;
  logic [1:0]   in_operation;
  logic [9:0]   in_page;
  logic [10:0]  in_end_page;
  logic [10:0]  in_count;
  logic [19:0]  in_frame;
  logic [11:0]  in_flags;
  logic         out_valid;
  logic         out_stall = 1'b0;
  logic [1:0]   out_status;
  logic [9:0]   out_run_start;
  logic [19:0]  out_old_frame;

  // shadow of the page table, one word per page
  logic [31:0]  page_words [TABLE_PAGES];
  page_resp_t   expected_q [$];
  page_resp_t   last_pred;
  page_resp_t   row_want;
  logic         row_typed;
  dir_row_t     dir_rows [$];
  int           mismatches;
  int           items_sent;
  int           idle_cycles;
  int           stall_left = 0;
  bit           tx_quiet;
  bit           rx_quiet;

  virtual_page_run_reserver_core #(
    .PAGE_COUNT(TABLE_PAGES)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_operation(in_operation),
    .in_page(in_page),
    .in_end_page(in_end_page),
    .in_count(in_count),
    .in_frame(in_frame),
    .in_flags(in_flags),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_run_start(out_run_start),
    .out_old_frame(out_old_frame)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic page_req_t mk_req(vprr_op_t op, int page, int end_pg, int cnt,
                                       int frm, int flg);
    page_req_t rq;
    rq.op       = op;
    rq.page     = page[9:0];
    rq.end_page = end_pg[10:0];
    rq.count    = cnt[10:0];
    rq.frame    = frm[19:0];
    rq.flags    = flg[11:0];
    return rq;
  endfunction

  function automatic page_resp_t mk_resp(vprr_status_t st, int rs, int of);
    page_resp_t rp;
    rp.status    = st;
    rp.run_start = rs[9:0];
    rp.old_frame = of[19:0];
    return rp;
  endfunction

  // applies one request to the shadow table and returns the result it gives
  function automatic page_resp_t predict_step(page_req_t r);
    page_resp_t res;
    int lim;
    int p;
    int run;
    int i;
    res = '0;
    res.status = ST_OK;
    case (r.op)
      OP_RESERVE: begin
        lim = PAGE_FIELD_PAGES;
        if (int'(r.end_page) < lim) lim = int'(r.end_page);
        p = int'(r.page);
        run = 0;
        while (p < lim && run < int'(r.count)) begin
          if (page_words[p] == ENTRY_FREE) run++;
          else run = 0;
          p++;
        end
        if (run == int'(r.count)) begin
          for (i = p - run; i < p; i++) page_words[i] = ENTRY_RESERVED;
          res.run_start = 10'(p - run);
        end else begin
          res.status = ST_NO_RUN;
        end
      end
      OP_RELEASE: begin
        for (i = 0; i < int'(r.count); i++) begin
          p = int'(r.page) + i;
          if (p < PAGE_FIELD_PAGES && page_words[p] == ENTRY_RESERVED) begin
            page_words[p] = ENTRY_FREE;
          end else begin
            res.status = ST_NOT_RESERVED;
            break;
          end
        end
      end
      OP_MAP: begin
        if (page_words[r.page] == ENTRY_RESERVED) page_words[r.page] = {r.frame, r.flags};
        else res.status = ST_NOT_RESERVED;
      end
      default: begin
        if (page_words[r.page] != ENTRY_FREE && page_words[r.page] != ENTRY_RESERVED) begin
          res.old_frame = page_words[r.page][31:12];
          page_words[r.page] = ENTRY_RESERVED;
        end else begin
          res.status = ST_NOT_MAPPED;
        end
      end
    endcase
    return res;
  endfunction

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h got 0x%0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  // result checking, prediction on every accepted item, and the stall watchdog
  always @(posedge clk) begin : monitor_blk
    page_resp_t got;
    page_resp_t want;
    page_req_t  seen;
    bit         in_take;
    bit         out_take;
    in_take  = rst_n && in_valid && in_stall === 1'b0;
    out_take = rst_n && out_valid === 1'b1 && !out_stall;
    if (out_take) begin
      got = {out_status, out_run_start, out_old_frame};
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, status %0d run_start %0d old_frame 0x%0h",
                 $time, got.status, got.run_start, got.old_frame);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        check_field("status", 32'(want.status), 32'(got.status));
        check_field("run_start", 32'(want.run_start), 32'(got.run_start));
        check_field("old_frame", 32'(want.old_frame), 32'(got.old_frame));
      end
    end
    if (in_take) begin
      seen = {in_operation, in_page, in_end_page, in_count, in_frame, in_flags};
      last_pred = predict_step(seen);
      expected_q.push_back(row_typed ? row_want : last_pred);
    end
    if (in_take || out_take) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side back-pressure: mostly short stalls, now and then a long one
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (!rx_quiet && $urandom_range(0, 2) == 0) begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50) : $urandom_range(0, 2);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic put_item(input page_req_t rq);
    int gap;
    int r;
    r = $urandom_range(0, 99);
    if (tx_quiet || r < 55) gap = 0;
    else if (r < 93) gap = $urandom_range(1, 4);
    else gap = $urandom_range(20, 60);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= rq.op;
    in_page      <= rq.page;
    in_end_page  <= rq.end_page;
    in_count     <= rq.count;
    in_frame     <= rq.frame;
    in_flags     <= rq.flags;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic add_row(page_req_t rq, logic typed, page_resp_t want);
    dir_row_t row;
    row.req   = rq;
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endtask

  // reserve a run, map and unmap some of its pages, then mostly give it back
  task automatic run_sequence();
    int n;
    int start;
    int stop;
    int first;
    int k;
    int pg;
    int r;
    int mapped [$];
    r = $urandom_range(0, 99);
    n = (r < 70) ? $urandom_range(1, 8) : (r < 95) ? $urandom_range(9, 64)
                                                    : $urandom_range(65, 400);
    start = $urandom_range(0, TABLE_PAGES - 1);
    stop  = ($urandom_range(0, 9) < 8) ? start + n + $urandom_range(0, 96) : TABLE_PAGES;
    if (stop > TABLE_PAGES) stop = TABLE_PAGES;
    put_item(mk_req(OP_RESERVE, start, stop, n, $urandom, $urandom));
    if (last_pred.status != ST_OK) return;
    first = last_pred.run_start;
    k = $urandom_range(0, (n < 4) ? n : 4);
    repeat (k) begin
      pg = first + $urandom_range(0, n - 1);
      r = $urandom_range(0, 19);
      // frame zero with flags zero or two makes the entry look free or reserved
      put_item(mk_req(OP_MAP, pg, $urandom_range(0, 1024), $urandom_range(0, 1024),
                      (r == 0) ? 0 : $urandom,
                      (r == 0) ? 2 * $urandom_range(0, 1) : $urandom));
      if (last_pred.status == ST_OK) mapped.push_back(pg);
    end
    if ($urandom_range(0, 3) == 0)
      put_item(mk_req(OP_UNMAP, first, 0, 0, $urandom, $urandom));
    foreach (mapped[i])
      if ($urandom_range(0, 9) < 8)
        put_item(mk_req(OP_UNMAP, mapped[i], $urandom_range(0, 1024), 0, $urandom, $urandom));
    r = $urandom_range(0, 19);
    if (r < 16)
      put_item(mk_req(OP_RELEASE, first, 0, n, $urandom, $urandom));
    else if (r < 18)
      put_item(mk_req(OP_RELEASE, first, 0, n + $urandom_range(1, 8), $urandom, $urandom));
  endtask

  initial begin
    bit paused;
    paused       = 1'b0;
    mismatches   = 0;
    items_sent   = 0;
    idle_cycles  = 0;
    tx_quiet     = 1'b0;
    rx_quiet     = 1'b0;
    row_typed    = 1'b0;
    row_want     = '0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_operation = OP_RESERVE;
    in_page      = '0;
    in_end_page  = '0;
    in_count     = '0;
    in_frame     = '0;
    in_flags     = '0;
    foreach (page_words[i]) page_words[i] = ENTRY_FREE;

    add_row(mk_req(OP_RESERVE, 0, 1024, 0, 0, 0), 1'b1, mk_resp(ST_OK, 0, 0));
    add_row(mk_req(OP_UNMAP, 0, 0, 0, 0, 0), 1'b1, mk_resp(ST_NOT_MAPPED, 0, 0));
    add_row(mk_req(OP_MAP, 0, 0, 0, 'hfffff, 'hfff), 1'b1, mk_resp(ST_NOT_RESERVED, 0, 0));
    add_row(mk_req(OP_RELEASE, 0, 0, 0, 0, 0), 1'b1, mk_resp(ST_OK, 0, 0));
    add_row(mk_req(OP_RELEASE, 5, 0, 1, 0, 0), 1'b1, mk_resp(ST_NOT_RESERVED, 0, 0));
    // whole table in one run, then nothing left
    add_row(mk_req(OP_RESERVE, 0, 1024, 1024, 0, 0), 1'b1, mk_resp(ST_OK, 0, 0));
    add_row(mk_req(OP_RESERVE, 0, 1024, 1, 0, 0), 1'b1, mk_resp(ST_NO_RUN, 0, 0));
    // release running off the top of the table
    add_row(mk_req(OP_RELEASE, 1020, 0, 5, 0, 0), 1'b0, '0);
    add_row(mk_req(OP_RESERVE, 1000, 1024, 4, 0, 0), 1'b0, '0);
    add_row(mk_req(OP_MAP, 1023, 0, 0, 'hfffff, 'hfff), 1'b0, '0);
    add_row(mk_req(OP_UNMAP, 1023, 0, 0, 0, 0), 1'b1, mk_resp(ST_OK, 0, 'hfffff));
    add_row(mk_req(OP_MAP, 1022, 0, 0, 0, 0), 1'b0, '0);
    add_row(mk_req(OP_UNMAP, 1022, 0, 0, 0, 0), 1'b0, '0);
    add_row(mk_req(OP_RESERVE, 1022, 1023, 1, 0, 0), 1'b0, '0);
    add_row(mk_req(OP_MAP, 1022, 0, 0, 0, 2), 1'b0, '0);
    add_row(mk_req(OP_UNMAP, 1022, 0, 0, 0, 0), 1'b0, '0);
    add_row(mk_req(OP_MAP, 1021, 0, 0, 'h12345, 'h801), 1'b0, '0);
    add_row(mk_req(OP_MAP, 1021, 0, 0, 0, 0), 1'b0, '0);
    add_row(mk_req(OP_RELEASE, 1021, 0, 1, 0, 0), 1'b0, '0);
    add_row(mk_req(OP_RELEASE, 0, 0, 1024, 0, 0), 1'b0, '0);
    // scan start past the bound, and zero count with an empty scan
    add_row(mk_req(OP_RESERVE, 5, 3, 1, 0, 0), 1'b1, mk_resp(ST_NO_RUN, 0, 0));
    add_row(mk_req(OP_RESERVE, 700, 0, 0, 0, 0), 1'b1, mk_resp(ST_OK, 700, 0));
    add_row(mk_req(OP_RESERVE, 0, 1024, 1024, 0, 0), 1'b1, mk_resp(ST_NO_RUN, 0, 0));
    add_row(mk_req(OP_RESERVE, 0, 16, 16, 0, 0), 1'b0, '0);
    add_row(mk_req(OP_UNMAP, 1021, 0, 0, 0, 0), 1'b1, mk_resp(ST_OK, 0, 'h12345));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      row_typed = dir_rows[i].typed;
      row_want  = dir_rows[i].want;
      put_item(dir_rows[i].req);
    end
    row_typed = 1'b0;

    while (items_sent < dir_rows.size() + RANDOM_ITEMS) begin
      tx_quiet = ($urandom_range(0, 5) == 0);
      rx_quiet = ($urandom_range(0, 5) == 0);
      // hold the sender once until every pending result has drained
      if (!paused && items_sent >= dir_rows.size() + RANDOM_ITEMS / 2) begin
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge clk);
        paused = 1'b1;
      end
      if ($urandom_range(0, 9) < 7) begin
        run_sequence();
      end else begin
        put_item(mk_req(vprr_op_t'($urandom_range(0, 3)), $urandom_range(0, TABLE_PAGES - 1),
                        $urandom_range(0, 1024),
                        ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1024)
                                                    : $urandom_range(0, 16),
                        $urandom, $urandom));
      end
    end
    in_valid <= 1'b0;

    while (expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
